// ----- hw/rtl/range_kth_smallest_select_defines.svh -----
// assertion macros for the range k-th smallest select block
`ifndef RANGE_KTH_SMALLEST_SELECT_DEFINES_SVH
`define RANGE_KTH_SMALLEST_SELECT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RKS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define RKS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/rks_pkg.sv -----
// shared constants for the range k-th smallest select block
`default_nettype none
package rks_pkg;
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_RNG  = 2'd2;
    localparam logic [1:0] ST_BAD_RANK = 2'd3;
endpackage
`default_nettype wire

// ----- hw/rtl/rks_ram.sv -----
// generic single port write, single port read ram with registered read
`default_nettype none
module rks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/rks_front.sv -----
// front end: accepts items, checks them against the sequence length, range and rank, clamps values, queues them
`default_nettype none
module rks_front
    import rks_pkg::*;
#(
    parameter int MAX_LEN     = 1024,
    parameter int VALUE_COUNT = 1024,
    parameter int LW          = 11,
    parameter int VW          = 10
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_command,
    input  wire logic [9:0]    s_value,
    input  wire logic [10:0]   s_range_start,
    input  wire logic [10:0]   s_range_end,
    input  wire logic [10:0]   s_k_rank,
    // queue output toward the back end
    output logic               q_valid,
    input  wire logic          q_ready,
    output logic [1:0]         q_status,
    output logic               q_append,
    output logic [VW-1:0]      q_value,
    output logic [LW-1:0]      q_rs,
    output logic [LW-1:0]      q_re,
    output logic [LW-1:0]      q_k
);
    localparam int QD = 2;

    // sequence length as seen by accepted appends
    logic [LW-1:0] len_reg, len_next;
    logic [1:0]    cnt_reg;
    logic          wp_reg, rp_reg;

    logic [1:0]    st_mem [QD];
    logic          ap_mem [QD];
    logic [VW-1:0] va_mem [QD];
    logic [LW-1:0] rs_mem [QD];
    logic [LW-1:0] re_mem [QD];
    logic [LW-1:0] k_mem  [QD];

    logic [1:0]    cls;
    logic          do_app;
    logic [VW-1:0] vsat;
    logic [11:0]   rlen;
    logic          push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;

    always_comb begin
        rlen   = {1'b0, s_range_end} - {1'b0, s_range_start} + 12'd1;
        do_app = 1'b0;
        cls    = ST_OK;
        if (s_command == CMD_APPEND) begin
            if ({1'b0, len_reg} >= (LW+1)'(MAX_LEN)) begin
                cls = ST_FULL;
            end else begin
                do_app = 1'b1;
            end
        end else begin
            if (s_range_start == '0 || s_range_end > len_reg
                    || s_range_start > s_range_end) begin
                cls = ST_BAD_RNG;
            end else if (s_k_rank == '0 || {1'b0, s_k_rank} > rlen) begin
                cls = ST_BAD_RANK;
            end
        end
        if ({22'd0, s_value} >= 32'(VALUE_COUNT)) begin
            vsat = VW'(VALUE_COUNT - 1);
        end else begin
            vsat = s_value[VW-1:0];
        end
        len_next = len_reg + LW'(push && do_app);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            len_reg <= len_next;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            st_mem[wp_reg] <= cls;
            ap_mem[wp_reg] <= do_app;
            va_mem[wp_reg] <= vsat;
            rs_mem[wp_reg] <= s_range_start[LW-1:0];
            re_mem[wp_reg] <= s_range_end[LW-1:0];
            k_mem[wp_reg]  <= s_k_rank[LW-1:0];
        end
    end

    assign q_status = st_mem[rp_reg];
    assign q_append = ap_mem[rp_reg];
    assign q_value  = va_mem[rp_reg];
    assign q_rs     = rs_mem[rp_reg];
    assign q_re     = re_mem[rp_reg];
    assign q_k      = k_mem[rp_reg];

    `include "range_kth_smallest_select_defines.svh"
    `RKS_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= 2'd2)
    `RKS_ASSERT_NXT(a_len_hold, aclk, aresetn, !(push && do_app), len_reg == $past(len_reg))
    `RKS_ASSERT_IMP(a_len_max, aclk, aresetn, 1'b1, {1'b0, len_reg} <= (LW+1)'(MAX_LEN))
endmodule
`default_nettype wire

// ----- hw/rtl/rks_back.sv -----
// back end: walks the persistent tree for appends and queries, holds the result
`default_nettype none
module rks_back
    import rks_pkg::*;
#(
    parameter int MAX_LEN     = 1024,
    parameter int VALUE_COUNT = 1024,
    parameter int LW          = 11,
    parameter int VW          = 10,
    parameter int NW          = 14,
    parameter int NODES       = 13312
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_valid,
    output logic              q_ready,
    input  wire logic [1:0]   q_status,
    input  wire logic         q_append,
    input  wire logic [VW-1:0] q_value,
    input  wire logic [LW-1:0] q_rs,
    input  wire logic [LW-1:0] q_re,
    input  wire logic [LW-1:0] q_k,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [1:0]        m_status,
    output logic [9:0]        m_kth_value
);
    localparam int RD = MAX_LEN + 1;
    localparam int RAW = $clog2(RD);
    localparam int LEVELS = $clog2(VALUE_COUNT);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROOT  = 3'd1; // root reads in flight
    localparam logic [2:0] S_QRD   = 3'd2; // node reads in flight
    localparam logic [2:0] S_QSTEP = 3'd3; // left child sums in flight
    localparam logic [2:0] S_ARD   = 3'd4;
    localparam logic [2:0] S_AWR   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [NW-1:0] ncnt_reg, ncnt_next;
    logic [LW-1:0] alen_reg, alen_next;
    logic          rinit_reg;
    logic [NW-1:0] u_reg, u_next, v_reg, v_next, cur_reg, cur_next, root_reg, root_next;
    logic [VW-1:0] lo_reg, lo_next, hi_reg, hi_next, idx_reg, idx_next;
    logic [LW-1:0] k_reg, k_next;
    logic          side_reg, side_next; // 0 reads the u root, 1 reads the v root
    logic [1:0]    ost_reg, ost_next;
    logic [9:0]    oval_reg, oval_next;
    logic          ov_reg, ov_next;
    // transaction kind and range end kept once the queue entry is gone
    logic          app_reg, app_next;
    logic [LW-1:0] re_reg, re_next;

    // root table
    logic          rt_we;
    logic [RAW-1:0] rt_wa, rt_ra;
    logic [NW-1:0] rt_wd, rt_rd;
    // node stores
    logic          nd_we;
    logic [NW-1:0] nd_wa, nd_ra;
    logic [LW-1:0] sum_wd, sum_rd;
    logic [NW-1:0] l_wd, l_rd, r_wd, r_rd;
    logic          nd_zero_reg; // last read hit node zero

    rks_ram #(.WIDTH(NW), .DEPTH(RD)) u_roots (
        .aclk(aclk), .we(rt_we), .waddr(rt_wa), .wdata(rt_wd), .raddr(rt_ra), .rdata(rt_rd)
    );
    rks_ram #(.WIDTH(LW), .DEPTH(NODES)) u_sum (
        .aclk(aclk), .we(nd_we), .waddr(nd_wa), .wdata(sum_wd), .raddr(nd_ra), .rdata(sum_rd)
    );
    rks_ram #(.WIDTH(NW), .DEPTH(NODES)) u_left (
        .aclk(aclk), .we(nd_we), .waddr(nd_wa), .wdata(l_wd), .raddr(nd_ra), .rdata(l_rd)
    );
    rks_ram #(.WIDTH(NW), .DEPTH(NODES)) u_right (
        .aclk(aclk), .we(nd_we), .waddr(nd_wa), .wdata(r_wd), .raddr(nd_ra), .rdata(r_rd)
    );

    // node zero and root zero are the empty tree, never written
    logic          root0_reg;
    logic [NW-1:0] rd_l, rd_r, rt_val;
    logic [LW-1:0] rd_sum;
    assign rd_sum = nd_zero_reg ? '0 : sum_rd;
    assign rd_l   = nd_zero_reg ? '0 : l_rd;
    assign rd_r   = nd_zero_reg ? '0 : r_rd;
    assign rt_val = root0_reg ? '0 : rt_rd;

    // query step latches u side, then v side
    logic [NW-1:0] ul_reg, ur_reg;
    logic [LW-1:0] usum_reg;
    logic [VW-1:0] mid;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    logic          qphase_reg, qphase_next;
    logic [NW-1:0] vl_reg, vr_reg, vl_next, vr_next;
    logic [NW-1:0] ul_next, ur_next;
    logic [LW-1:0] usum_next;
    logic [LW-1:0] lc;
    logic          root0_next, ndz_next;

    assign q_ready = (state_reg == S_IDLE) && !ov_reg;
    assign m_valid = ov_reg;
    assign m_status = ost_reg;
    assign m_kth_value = oval_reg;

    always_comb begin
        state_next = state_reg; ncnt_next = ncnt_reg; alen_next = alen_reg;
        u_next = u_reg; v_next = v_reg; cur_next = cur_reg; root_next = root_reg;
        lo_next = lo_reg; hi_next = hi_reg; idx_next = idx_reg; k_next = k_reg;
        side_next = side_reg; ost_next = ost_reg; oval_next = oval_reg;
        ov_next = ov_reg && !m_ready; qphase_next = qphase_reg;
        vl_next = vl_reg; vr_next = vr_reg; ul_next = ul_reg; ur_next = ur_reg;
        usum_next = usum_reg;
        app_next = app_reg; re_next = re_reg;
        rt_we = 1'b0; rt_wa = '0; rt_wd = '0; rt_ra = '0;
        nd_we = 1'b0; nd_wa = '0; sum_wd = '0; l_wd = '0; r_wd = '0; nd_ra = '0;
        root0_next = 1'b0; ndz_next = 1'b0;
        lc = '0;
        case (state_reg)
            S_IDLE: begin
                if (q_valid && !ov_reg) begin
                    k_next = q_k;
                    lo_next = '0; hi_next = VW'(VALUE_COUNT - 1);
                    idx_next = q_value;
                    app_next = q_append;
                    re_next = q_re;
                    if (q_status != ST_OK) begin
                        ost_next = q_status; oval_next = '0; ov_next = 1'b1;
                    end else if (q_append) begin
                        rt_ra = alen_reg[RAW-1:0];
                        root0_next = (alen_reg == '0);
                        side_next = 1'b0;
                        state_next = S_ROOT;
                    end else begin
                        rt_ra = RAW'(q_rs - LW'(1));
                        root0_next = (q_rs == LW'(1));
                        side_next = 1'b0;
                        state_next = S_ROOT;
                    end
                end
            end
            S_ROOT: begin
                if (!side_reg) begin
                    u_next = rt_val;
                    if (app_reg) begin
                        // append: read old root node
                        nd_ra = rt_val; ndz_next = (rt_val == '0);
                        cur_next = ncnt_reg; root_next = ncnt_reg;
                        state_next = S_ARD;
                    end else begin
                        rt_ra = re_reg[RAW-1:0]; root0_next = (re_reg == '0);
                        side_next = 1'b1;
                    end
                end else begin
                    v_next = rt_val;
                    nd_ra = u_reg; ndz_next = (u_reg == '0);
                    qphase_next = 1'b0;
                    state_next = (lo_reg == hi_reg) ? S_OUT : S_QRD;
                end
            end
            S_QRD: begin
                // qphase 0: u node data arrives, read v node
                if (!qphase_reg) begin
                    ul_next = rd_l; ur_next = rd_r;
                    nd_ra = v_reg; ndz_next = (v_reg == '0);
                    qphase_next = 1'b1;
                end else begin
                    vl_next = rd_l; vr_next = rd_r;
                    nd_ra = ul_reg; ndz_next = (ul_reg == '0);
                    qphase_next = 1'b0;
                    state_next = S_QSTEP;
                end
            end
            S_QSTEP: begin
                if (!qphase_reg) begin
                    usum_next = rd_sum;
                    nd_ra = vl_reg; ndz_next = (vl_reg == '0);
                    qphase_next = 1'b1;
                end else begin
                    lc = rd_sum - usum_reg;
                    if (k_reg <= lc) begin
                        u_next = ul_reg; v_next = vl_reg; hi_next = mid;
                        nd_ra = ul_reg; ndz_next = (ul_reg == '0);
                    end else begin
                        k_next = k_reg - lc;
                        u_next = ur_reg; v_next = vr_reg; lo_next = mid + VW'(1);
                        nd_ra = ur_reg; ndz_next = (ur_reg == '0);
                    end
                    qphase_next = 1'b0;
                    state_next = ((k_reg <= lc) ? (lo_reg == mid) : (mid + VW'(1) == hi_reg))
                        ? S_OUT : S_QRD;
                end
            end
            S_ARD: begin
                // keep the old node on the read port for the write cycle
                nd_ra = u_reg; ndz_next = (u_reg == '0);
                state_next = S_AWR;
            end
            S_AWR: begin
                nd_we = 1'b1; nd_wa = cur_reg;
                sum_wd = rd_sum + LW'(1);
                l_wd = rd_l; r_wd = rd_r;
                ncnt_next = cur_reg + NW'(1);
                if (lo_reg == hi_reg) begin
                    alen_next = alen_reg + LW'(1);
                    rt_we = 1'b1; rt_wa = RAW'(alen_reg + LW'(1)); rt_wd = root_reg;
                    ost_next = ST_OK; oval_next = '0; ov_next = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    if (idx_reg <= mid) begin
                        l_wd = cur_reg + NW'(1); nd_ra = rd_l; ndz_next = (rd_l == '0);
                        u_next = rd_l;
                        hi_next = mid;
                    end else begin
                        r_wd = cur_reg + NW'(1); nd_ra = rd_r; ndz_next = (rd_r == '0);
                        u_next = rd_r;
                        lo_next = mid + VW'(1);
                    end
                    cur_next = cur_reg + NW'(1);
                    state_next = S_ARD;
                end
            end
            S_OUT: begin
                ost_next = ST_OK; oval_next = lo_reg; ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; ncnt_reg <= NW'(1); alen_reg <= '0; ov_reg <= 1'b0;
            rinit_reg <= 1'b0;
        end else begin
            state_reg <= state_next; ncnt_reg <= ncnt_next; alen_reg <= alen_next;
            ov_reg <= ov_next; rinit_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        u_reg <= u_next; v_reg <= v_next; cur_reg <= cur_next; root_reg <= root_next;
        lo_reg <= lo_next; hi_reg <= hi_next; idx_reg <= idx_next; k_reg <= k_next;
        side_reg <= side_next; ost_reg <= ost_next; oval_reg <= oval_next;
        qphase_reg <= qphase_next; vl_reg <= vl_next; vr_reg <= vr_next;
        ul_reg <= ul_next; ur_reg <= ur_next; usum_reg <= usum_next;
        root0_reg <= root0_next; nd_zero_reg <= ndz_next;
        app_reg <= app_next; re_reg <= re_next;
    end

    `include "range_kth_smallest_select_defines.svh"
    `RKS_ASSERT_IMP(a_ready_idle, aclk, aresetn, q_ready, state_reg == S_IDLE)
    `RKS_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_kth_value))
    `RKS_ASSERT_IMP(a_ncnt_cap, aclk, aresetn, rinit_reg, ncnt_reg <= NW'(NODES))
endmodule
`default_nettype wire

// ----- hw/rtl/range_kth_smallest_select.sv -----
// top level of the range k-th smallest select block
//  channel  | handshake         | payload
//  input    | s_valid / s_ready | s_command s_value s_range_start s_range_end s_k_rank
//  result   | m_valid / m_ready | m_status m_kth_value
// an append reads and writes one node per level
// a query makes four node store reads per level
// rejected items skip the tree walk; a two deep queue separates checking from tree work
// reset is synchronous, active low; the empty tree is node zero and needs no clearing
// a stalled result holds in the output register and blocks the tree walker, then the input once the queue fills
`default_nettype none
module range_kth_smallest_select
    import rks_pkg::*;
#(
    parameter int MAX_LEN     = 1024,
    parameter int VALUE_COUNT = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [9:0]  s_value,
    input  wire logic [10:0] s_range_start,
    input  wire logic [10:0] s_range_end,
    input  wire logic [10:0] s_k_rank,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [9:0]       m_kth_value
);
    localparam int LW = 11;
    localparam int VW = 10;
    localparam int NODES = MAX_LEN * ($clog2(VALUE_COUNT) + 3) + 1;
    localparam int NW = $clog2(NODES + 1);

    logic          q_valid, q_ready, q_append;
    logic [1:0]    q_status;
    logic [VW-1:0] q_value;
    logic [LW-1:0] q_rs, q_re, q_k;

    rks_front #(.MAX_LEN(MAX_LEN), .VALUE_COUNT(VALUE_COUNT), .LW(LW), .VW(VW)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_value(s_value), .s_range_start(s_range_start),
        .s_range_end(s_range_end), .s_k_rank(s_k_rank),
        .q_valid(q_valid), .q_ready(q_ready), .q_status(q_status), .q_append(q_append),
        .q_value(q_value), .q_rs(q_rs), .q_re(q_re), .q_k(q_k)
    );

    rks_back #(.MAX_LEN(MAX_LEN), .VALUE_COUNT(VALUE_COUNT), .LW(LW), .VW(VW),
               .NW(NW), .NODES(NODES)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_status(q_status), .q_append(q_append), .q_value(q_value),
        .q_rs(q_rs), .q_re(q_re), .q_k(q_k),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_kth_value(m_kth_value)
    );
endmodule
`default_nettype wire
